/* hdl/mbb_pkg.sv */
// Package for the masked box blur block: sizes, register indexes and the
// control and status structs shared by the controller and the datapath.
// No dependencies.
package mbb_pkg;

  // Stream limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_HEIGHT = 4095;

  // History store holds every entry that a window can still reach.
  localparam int HIST_DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W     = $clog2(HIST_DEPTH);

  // Field and counter widths.
  localparam int W_W    = 11;
  localparam int H_W    = 12;
  localparam int R_W    = 2;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int IDX_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                 + MAX_RADIUS + 1);
  localparam int WIN_N  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2(WIN_N * 255 + 1);
  localparam int CNT_W  = $clog2(WIN_N + 1);
  localparam int A_W    = $clog2(2 * MAX_RADIUS + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  // Mask code of a contributing neighbor.
  localparam logic [7:0] MASK_FULL = 8'd255;

  // Register map.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic [W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [H_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [R_W-1:0] RADIUS_RESET = 2'd1;

  // Effective configuration seen by the datapath.
  typedef struct packed {
    logic [W_W-1:0]   w;
    logic [H_W-1:0]   h;
    logic [R_W-1:0]   r;
    logic [IDX_W-1:0] delay;
    logic [IDX_W-1:0] total;
  } cfg_t;

  // Commands from the controller.
  typedef struct packed {
    logic accept;
    logic rd_centre;
    logic cap_centre;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic out_load;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic produce;
    logic mask_nz;
    logic scan_last;
    logic n_zero;
    logic div_done;
    logic out_valid;
  } status_t;

endpackage

/* hdl/masked_box_blur_rgb_top.sv */
// Masked box blur: takes RGB pixels with a mask byte in raster order and
// returns each pixel blurred over the masked-in neighbors of its window.
//
// Input channel (in_valid/in_ready) carries one pixel or flush item per
// transaction; after the last pixel of a frame send flush items until the
// result with frame_end arrives. Output channel (out_valid/out_ready) carries
// one result per pixel, released by the item that arrives radius rows and
// radius pixels after it. The APB port holds frame_width, frame_height and
// blur_radius at byte addresses 0, 4 and 8; pready is always high, and a
// write to one of them restarts the stream at the frame start.
// Timing is set by the history RAM's single read port, one window entry a
// cycle, and by the bit-serial divider. An item that releases no result is
// only accepted and checked; one whose pixel has mask 0 also reads its
// centre and loads the output; one with no qualifying neighbor also scans
// the window; any other also divides, before the next item can be accepted.
// Reset restores 640 x 480, radius 1, and empties the output register.
// A result waits in the output register while the receiver stalls; the
// next item is still accepted and only the following result waits for it.
// Depends on mbb_pkg, mbb_ctrl and mbb_datapath.
module masked_box_blur_rgb_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        is_pixel,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  mask_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_end
);
  import mbb_pkg::*;

  logic [W_W-1:0]       width_reg;
  logic [H_W-1:0]       height_reg;
  logic [R_W-1:0]       radius_reg;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 restart;
  cfg_t                 cfg;
  cmd_t                 cmd;
  status_t              st;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
      radius_reg <= RADIUS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        CFG_WIDTH:  width_reg  <= pwdata[W_W-1:0];
        CFG_HEIGHT: height_reg <= pwdata[H_W-1:0];
        CFG_RADIUS: radius_reg <= pwdata[R_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_wr && (reg_idx == CFG_WIDTH || reg_idx == CFG_HEIGHT ||
                              reg_idx == CFG_RADIUS);

  always_comb begin
    case (reg_idx)
      CFG_WIDTH:  prdata = 32'(width_reg);
      CFG_HEIGHT: prdata = 32'(height_reg);
      CFG_RADIUS: prdata = 32'(radius_reg);
      default:    prdata = 32'd0;
    endcase
  end

  // Effective frame geometry with out-of-range values clamped.
  always_comb begin
    if (width_reg == '0) begin
      cfg.w = W_W'(1);
    end else if (width_reg > W_W'(MAX_WIDTH)) begin
      cfg.w = W_W'(MAX_WIDTH);
    end else begin
      cfg.w = width_reg;
    end
    cfg.h     = (height_reg == '0) ? H_W'(1) : height_reg;
    cfg.r     = (radius_reg > R_W'(MAX_RADIUS)) ? R_W'(MAX_RADIUS) : radius_reg;
    cfg.delay = IDX_W'(cfg.r) * IDX_W'(cfg.w) + IDX_W'(cfg.r);
    cfg.total = IDX_W'(cfg.w) * IDX_W'(cfg.h);
  end

  mbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  mbb_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .cfg        (cfg),
    .cmd        (cmd),
    .is_pixel   (is_pixel),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .mask_value (mask_value),
    .out_ready  (out_ready),
    .st         (st),
    .out_valid  (out_valid),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_end  (frame_end)
  );

endmodule

/* hdl/mbb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/mbb_div.sv */
// Iterative restoring divider for the three color sums, one bit per cycle.
// Depends on mbb_pkg.
module mbb_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mbb_pkg::SUM_W-1:0] dvd_r,
  input  logic [mbb_pkg::SUM_W-1:0] dvd_g,
  input  logic [mbb_pkg::SUM_W-1:0] dvd_b,
  input  logic [mbb_pkg::CNT_W-1:0] dvs,
  output logic [7:0]               q_r,
  output logic [7:0]               q_g,
  output logic [7:0]               q_b,
  output logic                     done
);
  import mbb_pkg::*;

  logic [SUM_W-1:0]  qr, qg, qb;
  logic [CNT_W-1:0]  rr, rg, rb;
  logic [CNT_W-1:0]  dvs_q;
  logic [STEP_W-1:0] cnt;
  logic              busy;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic logic [CNT_W+SUM_W-1:0] div_step(input logic [CNT_W-1:0] rem,
                                                      input logic [SUM_W-1:0] q,
                                                      input logic [CNT_W-1:0] d);
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] rem_n;
    logic             bit_n;
    t = {rem, q[SUM_W-1]};
    if (t >= {1'b0, d}) begin
      rem_n = CNT_W'(t - {1'b0, d});
      bit_n = 1'b1;
    end else begin
      rem_n = t[CNT_W-1:0];
      bit_n = 1'b0;
    end
    return {rem_n, q[SUM_W-2:0], bit_n};
  endfunction

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == STEP_W'(SUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Quotient and remainder registers of the three channels.
  always_ff @(posedge clk) begin
    if (start) begin
      qr    <= dvd_r;
      qg    <= dvd_g;
      qb    <= dvd_b;
      rr    <= '0;
      rg    <= '0;
      rb    <= '0;
      dvs_q <= dvs;
    end else if (busy) begin
      {rr, qr} <= div_step(rr, qr, dvs_q);
      {rg, qg} <= div_step(rg, qg, dvs_q);
      {rb, qb} <= div_step(rb, qb, dvs_q);
    end
  end

  // A mean never exceeds 255, so the low byte is the whole quotient.
  assign q_r  = qr[7:0];
  assign q_g  = qg[7:0];
  assign q_b  = qb[7:0];
  assign done = !busy;

endmodule

/* hdl/mbb_datapath.sv */
// Datapath of the masked box blur: stream position, history RAM, window scan,
// channel sums, divider and output register.
// Depends on mbb_pkg, mbb_ram and mbb_div.
module mbb_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  mbb_pkg::cfg_t    cfg,
  input  mbb_pkg::cmd_t    cmd,
  input  logic             is_pixel,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic [7:0]       mask_value,
  input  logic             out_ready,
  output mbb_pkg::status_t st,
  output logic             out_valid,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic             frame_end
);
  import mbb_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic [ADDR_W-1:0] wp, cur_wp;
  logic [COL_W-1:0]  cc, ic;
  logic [H_W-1:0]    cr, ir;
  logic              produce, last;
  logic              prod_now, last_now;
  logic [31:0]       wdata, rdata, centre;
  logic [ADDR_W-1:0] raddr, caddr, saddr, cdel, off;
  logic [ADDR_W:0]   cwrap, swrap;
  logic [A_W-1:0]    a, b, rlim;
  logic [ADDR_W-1:0] rowbase;
  logic [H_W:0]      ys;
  logic [W_W-1:0]    xs;
  logic              inb;
  logic              acc_v;
  logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
  logic [CNT_W-1:0]  n;
  logic [7:0]        q_r, q_g, q_b;
  logic              div_done;
  logic              use_mean;

  // Position of the arriving item and of the pixel whose result it releases.
  assign prod_now = idx >= cfg.delay;
  assign last_now = prod_now && ({1'b0, cc} == cfg.w - 1'b1) && (cr == cfg.h - 1'b1);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      idx <= '0;
      wp  <= '0;
      cc  <= '0;
      cr  <= '0;
    end else if (cmd.accept) begin
      if (last_now) begin
        idx <= '0;
        wp  <= '0;
        cc  <= '0;
        cr  <= '0;
      end else begin
        idx <= idx + 1'b1;
        wp  <= (wp == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wp + 1'b1;
        if (prod_now) begin
          if ({1'b0, cc} == cfg.w - 1'b1) begin
            cc <= '0;
            cr <= cr + 1'b1;
          end else begin
            cc <= cc + 1'b1;
          end
        end
      end
    end
  end

  // Snapshot of the item under work.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_wp  <= wp;
      ic      <= cc;
      ir      <= cr;
      produce <= prod_now;
      last    <= last_now;
    end
  end

  // Items past the frame end and flush items store as black, mask 0.
  assign wdata = (is_pixel && idx < cfg.total) ?
                 {mask_value, in_blue, in_green, in_red} : 32'd0;

  // Centre address: the entry written delay items ago, modulo the store.
  assign cdel  = ADDR_W'(cfg.delay);
  assign cwrap = {1'b0, cur_wp} + (ADDR_W + 1)'(HIST_DEPTH) - {1'b0, cdel};
  assign caddr = (cur_wp >= cdel) ? cur_wp - cdel : cwrap[ADDR_W-1:0];

  // Window address: offset back from the newest entry by a rows and b columns.
  assign off   = rowbase + ADDR_W'(b);
  assign swrap = {1'b0, cur_wp} + (ADDR_W + 1)'(HIST_DEPTH) - {1'b0, off};
  assign saddr = (cur_wp >= off) ? cur_wp - off : swrap[ADDR_W-1:0];
  assign raddr = cmd.rd_centre ? caddr : saddr;

  mbb_ram #(
    .WIDTH (32),
    .DEPTH (HIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wp),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Window neighbor must fall inside the frame.
  assign ys   = {1'b0, ir} + (H_W + 1)'(cfg.r);
  assign xs   = {1'b0, ic} + W_W'(cfg.r);
  assign inb  = (ys >= (H_W + 1)'(a)) && ((ys - (H_W + 1)'(a)) < {1'b0, cfg.h}) &&
                (xs >= W_W'(b)) && ((xs - W_W'(b)) < cfg.w);
  assign rlim = A_W'(2 * cfg.r);

  // Scan counters walk the window from the newest corner.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      a       <= '0;
      b       <= '0;
      rowbase <= '0;
    end else if (cmd.scan_step) begin
      if (b == rlim) begin
        b       <= '0;
        a       <= a + 1'b1;
        rowbase <= rowbase + ADDR_W'(cfg.w);
      end else begin
        b <= b + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_v <= 1'b0;
    end else begin
      acc_v <= cmd.scan_step && inb;
    end
  end

  // Channel sums over the qualifying neighbors, one read data per cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
      n     <= '0;
    end else if (acc_v && rdata[31:24] == MASK_FULL) begin
      sum_r <= sum_r + SUM_W'(rdata[7:0]);
      sum_g <= sum_g + SUM_W'(rdata[15:8]);
      sum_b <= sum_b + SUM_W'(rdata[23:16]);
      n     <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_centre) begin
      centre <= rdata;
    end
  end

  mbb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .dvd_r (sum_r),
    .dvd_g (sum_g),
    .dvd_b (sum_b),
    .dvs   (n),
    .q_r   (q_r),
    .q_g   (q_g),
    .q_b   (q_b),
    .done  (div_done)
  );

  // Output register: the mean where the pixel is masked and has neighbors.
  assign use_mean = (centre[31:24] != 8'd0) && (n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red   <= use_mean ? q_r : centre[7:0];
      out_green <= use_mean ? q_g : centre[15:8];
      out_blue  <= use_mean ? q_b : centre[23:16];
      frame_end <= last;
    end
  end

  // Status to the controller.
  assign st.produce   = produce;
  assign st.mask_nz   = rdata[31:24] != 8'd0;
  assign st.scan_last = (a == rlim) && (b == rlim);
  assign st.n_zero    = n == '0;
  assign st.div_done  = div_done;
  assign st.out_valid = out_valid;

endmodule

/* hdl/mbb_ctrl.sv */
// Controller of the masked box blur: sequences accept, centre read, window
// scan, division and output load. Depends on mbb_pkg.
module mbb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  mbb_pkg::status_t st,
  output logic             in_ready,
  output mbb_pkg::cmd_t    cmd
);
  import mbb_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CHECK  = 8'b0000_0010,
    S_CWAIT  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_DLOAD  = 8'b0010_0000,
    S_DWAIT  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.produce) begin
          cmd.rd_centre = 1'b1;
          state_next    = S_CWAIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CWAIT: begin
        cmd.cap_centre = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = st.mask_nz ? S_SCAN : S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DLOAD;
      end
      S_DLOAD: begin
        if (st.n_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (st.div_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!st.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/mbb_checker.sv */
// Port-level checks of the masked box blur, bound to the top level.
// Depends on masked_box_blur_rgb_top's port list only.
module mbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       frame_end
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({out_red, out_green, out_blue, frame_end}))
    else $error("result payload changed while stalled");

  // Reset empties the output register.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // Items are taken one at a time: ready drops after every transaction.
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted before the first was processed");

endmodule

bind masked_box_blur_rgb_top mbb_checker u_mbb_checker (.*);
